FILE: rtl/bpa_pkg.sv
package bpa_pkg;

  // Largest region order that the node memory is sized for.
  localparam int unsigned ORDER_LIMIT = 10;

  // Action codes of an input beat.
  localparam logic [1:0] ACT_ALLOC  = 2'd0;
  localparam logic [1:0] ACT_FREE   = 2'd1;
  localparam logic [1:0] ACT_LOOKUP = 2'd2;

  // Status codes of a result beat.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_BAD     = 2'd2;

  // Configuration register index.
  localparam logic REG_TREE_ORDER = 1'b0;

  // Reset value of the tree order register.
  localparam int unsigned TREE_ORDER_RESET = 10;

  typedef enum logic [2:0] {
    RD_ROOT  = 3'd0,
    RD_LEFT  = 3'd1,
    RD_RIGHT = 3'd2,
    RD_IDX   = 3'd3,
    RD_SIB   = 3'd4
  } rd_sel_e;

  typedef enum logic [1:0] {
    RES_ALLOC   = 2'd0,
    RES_FOUND   = 2'd1,
    RES_NOSPACE = 2'd2,
    RES_BAD     = 2'd3
  } res_kind_e;

  typedef struct packed {
    logic      init_step;
    logic      load;
    rd_sel_e   rd_sel;
    logic      latch_left;
    logic      descend;
    logic      mark;
    logic      found_write;
    logic      climb;
    logic      merge_write;
    logic      set_res;
    res_kind_e res_kind;
    logic      out_load;
  } bpa_cmd_t;

  typedef struct packed {
    logic init_last;
    logic reinit;
    logic act_alloc;
    logic act_free;
    logic page_bad;
    logic root_short;
    logic lvl_gt;
    logic lvl_dec_gt;
    logic node_used;
    logic idx_zero;
  } bpa_status_t;

endpackage

FILE: rtl/bpa_ctrl.sv
module bpa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  bpa_pkg::bpa_status_t status_i,
  output bpa_pkg::bpa_cmd_t    cmd_o
);

  typedef enum logic [12:0] {
    S_INIT  = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_DISP  = 13'b0000000000100,
    S_A_CHK = 13'b0000000001000,
    S_A_RL  = 13'b0000000010000,
    S_A_RR  = 13'b0000000100000,
    S_A_DEC = 13'b0000001000000,
    S_MARK  = 13'b0000010000000,
    S_F_RD  = 13'b0000100000000,
    S_F_CHK = 13'b0001000000000,
    S_U_RS  = 13'b0010000000000,
    S_U_WR  = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.rd_sel   = bpa_pkg::RD_ROOT;
    cmd_o.res_kind = bpa_pkg::RES_BAD;
    out_valid_d = out_valid_q & ~out_ready_i;
    unique case (state_q)
      S_INIT: begin
        cmd_o.init_step = 1'b1;
        if (status_i.init_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        if (status_i.act_alloc) begin
          cmd_o.rd_sel = bpa_pkg::RD_ROOT;
          state_d      = S_A_CHK;
        end else if (status_i.page_bad) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_kind = bpa_pkg::RES_BAD;
          state_d        = S_DONE;
        end else begin
          cmd_o.rd_sel = bpa_pkg::RD_IDX;
          state_d      = S_F_CHK;
        end
      end
      S_A_CHK: begin
        if (status_i.root_short) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_kind = bpa_pkg::RES_NOSPACE;
          state_d        = S_DONE;
        end else if (status_i.lvl_gt) begin
          state_d = S_A_RL;
        end else begin
          state_d = S_MARK;
        end
      end
      S_A_RL: begin
        cmd_o.rd_sel = bpa_pkg::RD_LEFT;
        state_d      = S_A_RR;
      end
      S_A_RR: begin
        cmd_o.rd_sel     = bpa_pkg::RD_RIGHT;
        cmd_o.latch_left = 1'b1;
        state_d          = S_A_DEC;
      end
      S_A_DEC: begin
        cmd_o.descend = 1'b1;
        state_d       = status_i.lvl_dec_gt ? S_A_RL : S_MARK;
      end
      S_MARK: begin
        cmd_o.mark     = 1'b1;
        cmd_o.set_res  = 1'b1;
        cmd_o.res_kind = bpa_pkg::RES_ALLOC;
        state_d        = S_U_RS;
      end
      S_F_RD: begin
        cmd_o.rd_sel = bpa_pkg::RD_IDX;
        state_d      = S_F_CHK;
      end
      S_F_CHK: begin
        priority if (status_i.node_used) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_kind = bpa_pkg::RES_FOUND;
          if (status_i.act_free) begin
            cmd_o.found_write = 1'b1;
            state_d           = S_U_RS;
          end else begin
            state_d = S_DONE;
          end
        end else if (status_i.idx_zero) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_kind = bpa_pkg::RES_BAD;
          state_d        = S_DONE;
        end else begin
          cmd_o.climb = 1'b1;
          state_d     = S_F_RD;
        end
      end
      S_U_RS: begin
        if (status_i.idx_zero) begin
          state_d = S_DONE;
        end else begin
          cmd_o.rd_sel = bpa_pkg::RD_SIB;
          state_d      = S_U_WR;
        end
      end
      S_U_WR: begin
        cmd_o.merge_write = 1'b1;
        state_d           = S_U_RS;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
    // A valid register write rebuilds the tree from scratch.
    if (status_i.reinit) state_d = S_INIT;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/bpa_dp.sv
module bpa_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [3:0]           cfg_wdata_i,
  output logic [3:0]           tree_order_o,
  input  logic [1:0]           action_i,
  input  logic [3:0]           req_order_i,
  input  logic [9:0]           page_offset_i,
  input  bpa_pkg::bpa_cmd_t    cmd_i,
  output bpa_pkg::bpa_status_t status_o,
  output logic [1:0]           status_o_f,
  output logic [9:0]           block_start_o,
  output logic [3:0]           block_order_o
);

  localparam int unsigned IW    = bpa_pkg::ORDER_LIMIT + 1;
  localparam int unsigned PW    = bpa_pkg::ORDER_LIMIT;
  localparam int unsigned NW    = $clog2(bpa_pkg::ORDER_LIMIT + 1) + 1;
  localparam int unsigned CW    = (NW > 5) ? NW + 1 : 6;
  localparam int unsigned NODES = (1 << (bpa_pkg::ORDER_LIMIT + 1)) - 1;
  localparam int unsigned TREE_ORDER_RESET_C =
    (bpa_pkg::ORDER_LIMIT < bpa_pkg::TREE_ORDER_RESET) ? bpa_pkg::ORDER_LIMIT :
                                                         bpa_pkg::TREE_ORDER_RESET;

  logic signed [NW-1:0] mem [NODES];
  logic signed [NW-1:0] rdata_q;
  logic [IW-1:0]        raddr, waddr;
  logic signed [NW-1:0] wdata;
  logic                 we;

  logic [3:0]           tree_order_q;
  logic [IW-1:0]        init_cnt_q, init_cnt_d;
  logic [4:0]           init_lvl_q, init_lvl_d;

  logic [1:0]           act_q;
  logic [3:0]           req_q;
  logic [9:0]           page_q;
  logic [IW-1:0]        idx_q, idx_d;
  logic [PW-1:0]        pos_q, pos_d;
  logic [3:0]           lvl_q, lvl_d;
  logic [3:0]           ord_q, ord_d;
  logic signed [NW-1:0] cur_q, cur_d;
  logic signed [NW-1:0] left_q;
  logic                 free_q;

  logic [1:0]           st_status_q;
  logic [9:0]           st_start_q;
  logic [3:0]           st_order_q;
  logic [1:0]           out_status_q;
  logic [9:0]           out_start_q;
  logic [3:0]           out_order_q;

  logic                 cfg_ok;
  logic [IW-1:0]        leaf_base, init_last_idx, parent, sibling;
  logic                 init_pow;
  logic signed [CW-1:0] req_w, ord_w, cur_w, sib_w, l_w, r_w, rd_w, max_w;
  logic                 go_right;
  logic signed [NW-1:0] merge_val;
  logic [IW-1:0]        shifted_pos;

  assign cfg_ok = cfg_we_i && (cfg_wdata_i != 4'd0) &&
                  (5'(cfg_wdata_i) <= 5'(bpa_pkg::ORDER_LIMIT));

  assign leaf_base     = (IW'(1) << tree_order_q) - IW'(1);
  assign init_last_idx = leaf_base << 1;
  assign init_pow      = (((init_cnt_q + IW'(1)) & init_cnt_q) == '0);
  assign parent        = (idx_q - IW'(1)) >> 1;
  assign sibling       = idx_q[0] ? idx_q + IW'(1) : idx_q - IW'(1);

  assign req_w = $signed(CW'({1'b0, req_q}));
  assign ord_w = $signed(CW'({1'b0, ord_q}));
  assign cur_w = CW'(cur_q);
  assign sib_w = CW'(rdata_q);
  assign rd_w  = CW'(rdata_q);
  assign l_w   = CW'(left_q);
  assign r_w   = CW'(rdata_q);
  assign max_w = (cur_w > sib_w) ? cur_w : sib_w;

  // Best fit: take the smaller child that still covers the request, left on a tie.
  assign go_right = (l_w < req_w) || (!(r_w < req_w) && (l_w > r_w));

  // A parent merges only when both children are wholly free.
  assign merge_val = (free_q && cur_w == ord_w && sib_w == ord_w) ?
                     NW'({1'b0, ord_q} + 5'd1) : NW'(max_w);

  assign init_lvl_d = init_pow ? init_lvl_q - 5'd1 : init_lvl_q;

  always_comb begin
    unique case (cmd_i.rd_sel)
      bpa_pkg::RD_ROOT:  raddr = '0;
      bpa_pkg::RD_LEFT:  raddr = (idx_q << 1) + IW'(1);
      bpa_pkg::RD_RIGHT: raddr = (idx_q << 1) + IW'(2);
      bpa_pkg::RD_IDX:   raddr = idx_q;
      bpa_pkg::RD_SIB:   raddr = sibling;
      default:           raddr = '0;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = idx_q;
    wdata = NW'(ord_q);
    priority if (cmd_i.init_step) begin
      we    = 1'b1;
      waddr = init_cnt_q;
      wdata = NW'(init_lvl_d);
    end else if (cmd_i.mark) begin
      we    = 1'b1;
      wdata = '1;
    end else if (cmd_i.found_write) begin
      we    = 1'b1;
      wdata = NW'(ord_q);
    end else if (cmd_i.merge_write) begin
      we    = 1'b1;
      waddr = parent;
      wdata = merge_val;
    end else begin
      we = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tree_order_q <= 4'(TREE_ORDER_RESET_C);
      init_cnt_q   <= '0;
      init_lvl_q   <= 5'(TREE_ORDER_RESET_C) + 5'd1;
    end else if (cfg_ok) begin
      tree_order_q <= cfg_wdata_i;
      init_cnt_q   <= '0;
      init_lvl_q   <= {1'b0, cfg_wdata_i} + 5'd1;
    end else if (cmd_i.init_step) begin
      init_cnt_q <= init_cnt_d;
      init_lvl_q <= init_lvl_d;
    end
  end

  assign init_cnt_d = init_cnt_q + IW'(1);

  always_comb begin
    idx_d = idx_q;
    pos_d = pos_q;
    lvl_d = lvl_q;
    ord_d = ord_q;
    cur_d = cur_q;
    priority if (cmd_i.load) begin
      ord_d = '0;
      lvl_d = tree_order_o;
      if (action_i == bpa_pkg::ACT_ALLOC) begin
        idx_d = '0;
        pos_d = '0;
      end else begin
        idx_d = IW'(page_offset_i) + leaf_base;
        pos_d = PW'(page_offset_i);
      end
    end else if (cmd_i.descend) begin
      idx_d = (idx_q << 1) + IW'(1) + IW'(go_right);
      pos_d = PW'({pos_q, go_right});
      lvl_d = lvl_q - 4'd1;
    end else if (cmd_i.mark) begin
      cur_d = '1;
    end else if (cmd_i.found_write) begin
      cur_d = NW'(ord_q);
    end else if (cmd_i.climb) begin
      idx_d = parent;
      pos_d = pos_q >> 1;
      ord_d = ord_q + 4'd1;
    end else if (cmd_i.merge_write) begin
      idx_d = parent;
      ord_d = ord_q + 4'd1;
      cur_d = merge_val;
    end else begin
      idx_d = idx_q;
    end
  end

  assign shifted_pos = IW'(pos_q) << ((cmd_i.res_kind == bpa_pkg::RES_ALLOC) ? req_q : ord_q);

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    pos_q <= pos_d;
    lvl_q <= lvl_d;
    ord_q <= ord_d;
    cur_q <= cur_d;
    if (cmd_i.load) begin
      act_q  <= action_i;
      req_q  <= req_order_i;
      page_q <= page_offset_i;
      free_q <= (action_i == bpa_pkg::ACT_FREE);
    end
    if (cmd_i.latch_left) left_q <= rdata_q;
    if (cmd_i.set_res) begin
      unique case (cmd_i.res_kind)
        bpa_pkg::RES_ALLOC: begin
          st_status_q <= bpa_pkg::ST_OK;
          st_start_q  <= 10'(shifted_pos);
          st_order_q  <= req_q;
        end
        bpa_pkg::RES_FOUND: begin
          st_status_q <= bpa_pkg::ST_OK;
          st_start_q  <= 10'(shifted_pos);
          st_order_q  <= ord_q;
        end
        bpa_pkg::RES_NOSPACE: begin
          st_status_q <= bpa_pkg::ST_NOSPACE;
          st_start_q  <= '0;
          st_order_q  <= '0;
        end
        default: begin
          st_status_q <= bpa_pkg::ST_BAD;
          st_start_q  <= '0;
          st_order_q  <= '0;
        end
      endcase
    end
    if (cmd_i.out_load) begin
      out_status_q <= st_status_q;
      out_start_q  <= st_start_q;
      out_order_q  <= st_order_q;
    end
  end

  always_comb begin
    status_o.init_last  = (init_cnt_q == init_last_idx);
    status_o.reinit     = cfg_ok;
    status_o.act_alloc  = (act_q == bpa_pkg::ACT_ALLOC);
    status_o.act_free   = (act_q == bpa_pkg::ACT_FREE);
    status_o.page_bad   = (act_q != bpa_pkg::ACT_FREE && act_q != bpa_pkg::ACT_LOOKUP) ||
                          ((page_q >> tree_order_q) != 10'd0);
    status_o.root_short = (rd_w < req_w);
    status_o.lvl_gt     = (lvl_q > req_q);
    status_o.lvl_dec_gt = (({1'b0, lvl_q} - 5'd1) > {1'b0, req_q});
    status_o.node_used  = (rdata_q == '1);
    status_o.idx_zero   = (idx_q == '0);
  end

  assign tree_order_o  = tree_order_q;
  assign status_o_f    = out_status_q;
  assign block_start_o = out_start_q;
  assign block_order_o = out_order_q;

endmodule

FILE: rtl/buddy_page_allocator.sv
// Binary buddy page allocator over a region of 2^tree_order pages.
// Input beats arrive on the s_t* channel: action 0 allocates a block of
// 2^req_order pages, 1 frees the block holding page_offset, 2 looks it up.
// Each input beat gives exactly one result beat on the m_t* channel with a
// status, the block's first page and its order.
// One item is in work at a time. An allocate that lands d = tree_order -
// req_order levels below the root descends through d levels, then climbs
// back to the root: the descent reads both children per level through the
// single read port of the node memory, the climb reads one sibling and
// writes one parent per level. s_tready rises in the cycle after the result
// loads.
// After reset, and after each valid write of tree_order over the APB port,
// the node memory is rebuilt one node a cycle, 2^(tree_order+1)-1 nodes;
// s_tready stays low meanwhile.
// A finished result sits in an output register; the next input beat is taken
// while it waits. If m_tready stays low, the following result is held back
// until the register empties.
module buddy_page_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // action[1:0], req_order[5:2], page_offset[15:6]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // status[1:0], block_start[11:2], block_order[15:12]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  bpa_pkg::bpa_cmd_t    cmd;
  bpa_pkg::bpa_status_t status;
  logic [3:0]           tree_order;
  logic                 cfg_we;
  logic [1:0]           res_status;
  logic [9:0]           res_start;
  logic [3:0]           res_order;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == bpa_pkg::REG_TREE_ORDER);
  assign prdata = (paddr[2] == bpa_pkg::REG_TREE_ORDER) ? 32'(tree_order) : 32'd0;

  bpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_tvalid),
    .in_ready_o  (s_tready),
    .out_valid_o (m_tvalid),
    .out_ready_i (m_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bpa_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (pwdata[3:0]),
    .tree_order_o  (tree_order),
    .action_i      (s_tdata[1:0]),
    .req_order_i   (s_tdata[5:2]),
    .page_offset_i (s_tdata[15:6]),
    .cmd_i         (cmd),
    .status_o      (status),
    .status_o_f    (res_status),
    .block_start_o (res_start),
    .block_order_o (res_order)
  );

  assign m_tdata = {res_order, res_start, res_status};

endmodule

FILE: bench/tb_buddy_page_allocator.sv
module tb_buddy_page_allocator;

  localparam int unsigned ORDER_MAX = 10;
  localparam int unsigned NODES = (1 << (ORDER_MAX + 1)) - 1;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [9:0] page;
    logic [3:0] req;
    logic [1:0] act;
  } req_beat_t;

  typedef struct packed {
    logic [3:0] ord;
    logic [9:0] start;
    logic [1:0] st;
  } rsp_beat_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;  // action[1:0], req_order[5:2], page_offset[15:6]
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;  // status[1:0], block_start[11:2], block_order[15:12]
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  buddy_page_allocator u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  req_beat_t   pending_reqs[$];
  rsp_beat_t   expected_rsps[$];
  int          free_order[NODES];
  int unsigned cur_order;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned cycle_cnt;
  int unsigned err_cnt;

  // Rebuild the tree as wholly free: every node holds its level's order.
  function automatic void tree_rebuild(int unsigned t);
    int lvl;
    int unsigned n;
    lvl = t + 1;
    n = (1 << (t + 1)) - 1;
    for (int unsigned i = 0; i < NODES; i++) begin
      free_order[i] = 0;
      if (i < n) begin
        if (((i + 1) & i) == 0) lvl--;
        free_order[i] = lvl;
      end
    end
  endfunction

  function automatic rsp_beat_t alloc_step(req_beat_t b);
    rsp_beat_t   r;
    int          req, l, rr;
    int unsigned idx, li, ri, ord;
    r = '0;
    req = b.req;
    if (b.act == bpa_pkg::ACT_ALLOC) begin
      if (free_order[0] < req) begin
        r.st = bpa_pkg::ST_NOSPACE;
        return r;
      end
      idx = 0;
      for (int lvl = cur_order; lvl > req; lvl--) begin
        li = 2 * idx + 1;
        ri = 2 * idx + 2;
        if (ri >= NODES) break;
        l = free_order[li];
        rr = free_order[ri];
        if (l < req) idx = ri;
        else if (rr < req) idx = li;
        else idx = (l <= rr) ? li : ri;
      end
      free_order[idx] = -1;
      r.start = 10'(((idx + 1) << req) - (1 << cur_order));
      r.ord = b.req;
      while (idx != 0) begin
        idx = (idx - 1) >> 1;
        l = free_order[2 * idx + 1];
        rr = free_order[2 * idx + 2];
        free_order[idx] = (l > rr) ? l : rr;
      end
      return r;
    end
    if ((b.act != bpa_pkg::ACT_FREE && b.act != bpa_pkg::ACT_LOOKUP) ||
        b.page >= (1 << cur_order)) begin
      r.st = bpa_pkg::ST_BAD;
      return r;
    end
    idx = b.page + (1 << cur_order) - 1;
    ord = 0;
    while (free_order[idx] != -1) begin
      if (idx == 0) begin
        r.st = bpa_pkg::ST_BAD;
        return r;
      end
      idx = (idx - 1) >> 1;
      ord++;
    end
    r.start = 10'(((idx + 1) << ord) - (1 << cur_order));
    r.ord = 4'(ord);
    if (b.act == bpa_pkg::ACT_FREE) begin
      free_order[idx] = ord;
      while (idx != 0) begin
        idx = (idx - 1) >> 1;
        ord++;
        l = free_order[2 * idx + 1];
        rr = free_order[2 * idx + 2];
        // Merge only when both halves are wholly free.
        if (l == int'(ord) - 1 && rr == int'(ord) - 1) free_order[idx] = ord;
        else free_order[idx] = (l > rr) ? l : rr;
      end
    end
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Request driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      if (s_tvalid && s_tready) expected_rsps.push_back(alloc_step(req_beat_t'(s_tdata)));
      if (!(s_tvalid && !s_tready)) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tdata  <= pending_reqs.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Response monitor.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected beat %h", $time, m_tdata);
          err_cnt++;
        end else if (rsp_beat_t'(m_tdata) !== expected_rsps[0]) begin
          $display("%0t: mismatch expected st=%0d start=%0d ord=%0d",
                   $time, expected_rsps[0].st, expected_rsps[0].start, expected_rsps[0].ord,
                   " actual st=%0d start=%0d ord=%0d",
                   m_tdata[1:0], m_tdata[11:2], m_tdata[15:12]);
          err_cnt++;
          void'(expected_rsps.pop_front());
        end else begin
          void'(expected_rsps.pop_front());
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic push_req(logic [1:0] act, int unsigned req, int unsigned page);
    req_beat_t b;
    b.act = act;
    b.req = 4'(req);
    b.page = 10'(page);
    pending_reqs.push_back(b);
  endtask

  task automatic wait_idle();
    do @(posedge clk_i); while (pending_reqs.size() != 0 || s_tvalid || expected_rsps.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  // Writes the order register, then reads it back.
  task automatic write_order(logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {bpa_pkg::REG_TREE_ORDER, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (value[3:0] >= 1 && value[3:0] <= ORDER_MAX) begin
      cur_order = value[3:0];
      tree_rebuild(cur_order);
    end
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (pready !== 1'b1 || prdata !== 32'(cur_order)) begin
      $display("%0t: mismatch expected order=%0d ready=1 actual order=%0d ready=%b",
               $time, cur_order, prdata, pready);
      err_cnt++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic add_random(int unsigned n);
    int unsigned r, top;
    top = (1 << cur_order) - 1;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 45)
        push_req(bpa_pkg::ACT_ALLOC, $urandom_range(cur_order > 3 ? 3 : cur_order),
                 $urandom_range(1023));
      else if (r < 80)
        push_req(bpa_pkg::ACT_FREE, $urandom_range(15), $urandom_range(top));
      else if (r < 92)
        push_req(bpa_pkg::ACT_LOOKUP, $urandom_range(15), $urandom_range(top));
      else
        push_req(2'($urandom_range(3)), $urandom_range(15), $urandom_range(1023));
    end
  endtask

  initial begin
    int unsigned orders[10] = '{1, 3, 4, 5, 6, 10, 2, 5, 4, 10};
    cycle_cnt = 0;
    err_cnt = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cur_order = bpa_pkg::TREE_ORDER_RESET;
    tree_rebuild(cur_order);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Whole region, too-large requests, double free, unallocated pages.
    push_req(bpa_pkg::ACT_ALLOC, 10, 0);
    push_req(bpa_pkg::ACT_ALLOC, 0, 0);
    push_req(bpa_pkg::ACT_LOOKUP, 0, 1023);
    push_req(bpa_pkg::ACT_FREE, 0, 512);
    push_req(bpa_pkg::ACT_FREE, 0, 512);
    push_req(bpa_pkg::ACT_ALLOC, 0, 1023);
    push_req(bpa_pkg::ACT_ALLOC, 1, 0);
    push_req(bpa_pkg::ACT_ALLOC, 15, 0);
    push_req(bpa_pkg::ACT_LOOKUP, 0, 0);
    push_req(bpa_pkg::ACT_LOOKUP, 0, 3);
    push_req(bpa_pkg::ACT_LOOKUP, 0, 1);
    push_req(2'd3, 15, 1023);
    push_req(bpa_pkg::ACT_FREE, 0, 0);
    push_req(bpa_pkg::ACT_FREE, 0, 2);
    push_req(bpa_pkg::ACT_ALLOC, 9, 0);
    push_req(bpa_pkg::ACT_ALLOC, 9, 0);
    push_req(bpa_pkg::ACT_ALLOC, 9, 0);
    push_req(bpa_pkg::ACT_FREE, 0, 1023);
    wait_idle();
    // Writes outside the legal range leave order and tree alone.
    write_order(32'd0);
    write_order(32'd15);
    push_req(bpa_pkg::ACT_LOOKUP, 0, 0);
    wait_idle();

    for (int p = 0; p < 10; p++) begin
      write_order(orders[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      if (p == 0) begin
        // Pages past the end of the smallest region, whole-region and too-large allocates.
        push_req(bpa_pkg::ACT_FREE, 0, 2);
        push_req(bpa_pkg::ACT_LOOKUP, 0, 1023);
        push_req(bpa_pkg::ACT_ALLOC, 1, 0);
        push_req(bpa_pkg::ACT_ALLOC, 2, 0);
        push_req(bpa_pkg::ACT_FREE, 0, 1);
      end
      add_random(55);
      wait_idle();
    end

    repeat (50) @(posedge clk_i);
    if (err_cnt == 0 && expected_rsps.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/bpa_pkg.sv
rtl/bpa_ctrl.sv
rtl/bpa_dp.sv
rtl/buddy_page_allocator.sv
bench/tb_buddy_page_allocator.sv
